@@ rtl/qpht_pkg.sv @@
package qpht_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOSLOT   = 2'd2,
    ST_MAXED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2,
    TAG_RSVD  = 2'd3
  } tag_t;

  localparam logic [31:0] MIX_MULT = 32'h045d9f3b;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_MIX_A,
    S_MIX_B,
    S_MIX_C,
    S_MOD,
    S_PIDX,
    S_PRD,
    S_PCHK,
    S_WR,
    S_GCLR,
    S_GRD,
    S_GCHK,
    S_GWR,
    S_DONE
  } state_t;

endpackage

@@ rtl/qpht_mix.sv @@
// Hash mixer: one 32x32 multiply per step; the top module applies two steps.
module qpht_mix (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [31:0] key,
  output logic [31:0] hash
);

  logic [31:0] x_r;
  logic [31:0] x_nxt;

  always_comb begin
    x_nxt = x_r;
    if (load) begin
      x_nxt = key;
    end else if (step) begin
      x_nxt = ((x_r >> 16) ^ x_r) * qpht_pkg::MIX_MULT;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  assign hash = (x_r >> 16) ^ x_r;

endmodule

@@ rtl/quadratic_probe_hash_table_top.sv @@
// Quadratic-probe hash table, one operation at a time; busy is high until the result beat.
// Steps: hashing, the home-slot remainder, set-up, then a read and a check per probe
// slot (up to size+1 probes), then the write and the result beat; a counter read skips to it.
// Growth adds a 2*size-slot clear sweep, a read of each old slot and a rehash per move.
// Throughput: one operation per result beat; the receiver cannot stall, a beat lasts 1 cycle.
// Reset: synchronous; then a sweep of both banks empties every tag (busy high).
module quadratic_probe_hash_table_top #(
  parameter int INITIAL_SLOTS = 16,
  parameter int MAX_SLOTS     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_read_value,
  output logic [10:0] out_table_size,
  output logic [10:0] out_element_count,
  output logic [31:0] out_insert_count
);

  localparam int AW = $clog2(MAX_SLOTS);   // slot index bits in one bank
  localparam int SW = AW + 1;              // size needs to hold MAX_SLOTS
  localparam int MW = AW + 1;              // memory address incl bank bit
  localparam int DEPTH = 1 << MW;          // two banks of 2**AW slots

  // slot memory: tag, key, value
  logic [65:0] mem [DEPTH];
  logic [65:0] rd_r;
  logic        we;
  logic [MW-1:0] waddr, raddr;
  logic [65:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  qpht_pkg::state_t st_r, st_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] key_r, key_nxt, val_r, val_nxt;
  logic        bank_r, bank_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [SW-1:0] live_r, live_nxt;
  logic [31:0] tally_r, tally_nxt;
  logic [SW:0] cnt_r, cnt_nxt;        // probe number i, 0..size
  logic [SW-1:0] idx_r, idx_nxt;      // current probe slot
  logic [SW-1:0] inc_r, inc_nxt;      // i*i step kept as 2i+1 increments mod size
  logic [31:0] rem_r, rem_nxt;        // restoring remainder
  logic [5:0]  bit_r, bit_nxt;
  logic [MW:0] clr_r, clr_nxt;
  logic [SW-1:0] gsrc_r, gsrc_nxt;    // old slot scanned by the rehash
  logic [SW:0] moved_r, moved_nxt;
  logic [1:0]  mixc_r, mixc_nxt;
  logic        grow_r, grow_nxt;      // probing into the new bank
  logic [1:0]  ostat_r, ostat_nxt;
  logic [31:0] orv_r, orv_nxt;
  logic        ov_r, ov_nxt;

  logic        mix_load, mix_step;
  logic [31:0] hash;

  qpht_mix u_mix (
    .clk  (clk),
    .load (mix_load),
    .step (mix_step),
    .key  (key_r),
    .hash (hash)
  );

  logic [SW-1:0] psize;
  logic          pbank;
  logic [1:0]    rtag;
  logic [31:0]   rkey, rval;
  logic [32:0]   rem_sh;
  logic [SW:0]   idx_sum, inc_sum;

  assign rtag = rd_r[65:64];
  assign rkey = rd_r[63:32];
  assign rval = rd_r[31:0];
  assign psize = grow_r ? {size_r[SW-2:0], 1'b0} : size_r;
  assign pbank = grow_r ? ~bank_r : bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= qpht_pkg::S_CLR;
      bank_r <= 1'b0;
      size_r <= SW'(INITIAL_SLOTS);
      live_r <= '0;
      tally_r <= '0;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      bank_r <= bank_nxt;
      size_r <= size_nxt;
      live_r <= live_nxt;
      tally_r <= tally_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; key_r <= key_nxt; val_r <= val_nxt;
    cnt_r <= cnt_nxt; idx_r <= idx_nxt; inc_r <= inc_nxt;
    rem_r <= rem_nxt; bit_r <= bit_nxt; gsrc_r <= gsrc_nxt; moved_r <= moved_nxt;
    mixc_r <= mixc_nxt; grow_r <= grow_nxt; ostat_r <= ostat_nxt; orv_r <= orv_nxt;
  end

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; key_nxt = key_r; val_nxt = val_r;
    bank_nxt = bank_r; size_nxt = size_r; live_nxt = live_r; tally_nxt = tally_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; inc_nxt = inc_r;
    rem_nxt = rem_r; bit_nxt = bit_r; clr_nxt = clr_r; gsrc_nxt = gsrc_r;
    moved_nxt = moved_r; mixc_nxt = mixc_r; grow_nxt = grow_r;
    ostat_nxt = ostat_r; orv_nxt = orv_r; ov_nxt = 1'b0;
    mix_load = 1'b0; mix_step = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = {pbank, idx_r[AW-1:0]};
    rem_sh = '0; idx_sum = '0; inc_sum = '0;
    unique case (st_r)
      qpht_pkg::S_CLR: begin
        // sweep every tag to empty after reset
        we = 1'b1;
        waddr = clr_r[MW-1:0];
        wdata = {qpht_pkg::TAG_EMPTY, 64'd0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (MW+1)'(DEPTH - 1)) begin
          st_nxt = qpht_pkg::S_IDLE;
        end
      end
      qpht_pkg::S_IDLE: begin
        if (start) begin
          op_nxt = in_operation;
          key_nxt = in_key;
          val_nxt = in_value;
          ostat_nxt = qpht_pkg::ST_OK;
          orv_nxt = '0;
          grow_nxt = 1'b0;
          if (in_operation == qpht_pkg::OP_READ) begin
            st_nxt = qpht_pkg::S_DONE;
          end else begin
            st_nxt = qpht_pkg::S_MIX_A;
          end
        end
      end
      qpht_pkg::S_MIX_A: begin
        mix_load = 1'b1;
        mixc_nxt = '0;
        st_nxt = qpht_pkg::S_MIX_B;
      end
      qpht_pkg::S_MIX_B: begin
        mix_step = 1'b1;
        mixc_nxt = mixc_r + 1'b1;
        if (mixc_r == 2'd1) begin
          st_nxt = qpht_pkg::S_MIX_C;
        end
      end
      qpht_pkg::S_MIX_C: begin
        rem_nxt = '0;
        bit_nxt = 6'd31;
        key_nxt = key_r;
        st_nxt = qpht_pkg::S_MOD;
      end
      qpht_pkg::S_MOD: begin
        // one remainder bit a cycle: hash mod psize
        rem_sh = {rem_r, hash[bit_r[4:0]]};
        if (rem_sh >= 33'(psize)) begin
          rem_nxt = 32'(rem_sh - 33'(psize));
        end else begin
          rem_nxt = rem_sh[31:0];
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 6'd0) begin
          st_nxt = qpht_pkg::S_PIDX;
        end
      end
      qpht_pkg::S_PIDX: begin
        idx_nxt = rem_r[SW-1:0];
        inc_nxt = (psize == SW'(1)) ? '0 : SW'(1);
        cnt_nxt = '0;
        st_nxt = qpht_pkg::S_PRD;
      end
      qpht_pkg::S_PRD: begin
        st_nxt = qpht_pkg::S_PCHK;
      end
      qpht_pkg::S_PCHK: begin
        if (op_r == qpht_pkg::OP_PUT || grow_r) begin
          if (rtag != qpht_pkg::TAG_LIVE || rkey == key_r) begin
            st_nxt = qpht_pkg::S_WR;
          end
        end else if (rtag == qpht_pkg::TAG_LIVE && rkey == key_r) begin
          st_nxt = qpht_pkg::S_WR;
        end
        if (st_nxt == qpht_pkg::S_PCHK) begin
          if (cnt_r == (SW+1)'(psize)) begin
            if (grow_r) begin
              // abandon growth, keep old bank
              ostat_nxt = qpht_pkg::ST_NOSLOT;
              tally_nxt = tally_r + 32'd1;
              st_nxt = qpht_pkg::S_DONE;
            end else begin
              ostat_nxt = (op_r == qpht_pkg::OP_PUT) ? qpht_pkg::ST_NOSLOT
                                                    : qpht_pkg::ST_NOTFOUND;
              st_nxt = qpht_pkg::S_DONE;
            end
          end else begin
            // advance: idx += 2i+1 mod size, inc += 2 mod size
            idx_sum = {1'b0, idx_r} + {1'b0, inc_r};
            idx_nxt = (idx_sum >= (SW+1)'(psize)) ? SW'(idx_sum - (SW+1)'(psize))
                                                  : idx_sum[SW-1:0];
            inc_sum = {1'b0, inc_r} + (SW+1)'(2);
            if (inc_sum >= (SW+1)'(psize)) begin
              inc_sum = inc_sum - (SW+1)'(psize);
            end
            if (inc_sum >= (SW+1)'(psize)) begin
              inc_sum = inc_sum - (SW+1)'(psize);
            end
            inc_nxt = inc_sum[SW-1:0];
            cnt_nxt = cnt_r + 1'b1;
            st_nxt = qpht_pkg::S_PRD;
          end
        end
      end
      qpht_pkg::S_WR: begin
        we = 1'b1;
        waddr = {pbank, idx_r[AW-1:0]};
        if (grow_r) begin
          wdata = {qpht_pkg::TAG_LIVE, key_r, val_r};
          moved_nxt = moved_r + 1'b1;
          st_nxt = qpht_pkg::S_GRD;
        end else begin
          unique case (op_r)
            qpht_pkg::OP_GET: begin
              we = 1'b0;
              orv_nxt = rval;
              st_nxt = qpht_pkg::S_DONE;
            end
            qpht_pkg::OP_REMOVE: begin
              wdata = {qpht_pkg::TAG_TOMB, rkey, rval};
              live_nxt = live_r - 1'b1;
              st_nxt = qpht_pkg::S_DONE;
            end
            default: begin
              wdata = {qpht_pkg::TAG_LIVE, key_r, val_r};
              live_nxt = live_r + ((rtag != qpht_pkg::TAG_LIVE) ? SW'(1) : SW'(0));
              st_nxt = qpht_pkg::S_DONE;
              if ({live_nxt, 1'b0} >= {1'b0, size_r}) begin
                if ({size_r, 1'b0} > (SW+1)'(MAX_SLOTS)) begin
                  ostat_nxt = qpht_pkg::ST_MAXED;
                  tally_nxt = tally_r + 32'd1;
                end else begin
                  clr_nxt = '0;
                  st_nxt = qpht_pkg::S_GCLR;
                end
              end else begin
                tally_nxt = tally_r + 32'd1;
              end
            end
          endcase
        end
      end
      qpht_pkg::S_GCLR: begin
        // empty the new bank over twice the current size
        we = 1'b1;
        waddr = {~bank_r, clr_r[AW-1:0]};
        wdata = {qpht_pkg::TAG_EMPTY, 64'd0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (MW+1)'({size_r, 1'b0} - 1'b1)) begin
          gsrc_nxt = '0;
          moved_nxt = '0;
          grow_nxt = 1'b1;
          st_nxt = qpht_pkg::S_GRD;
        end
      end
      qpht_pkg::S_GRD: begin
        // fetch next old slot, or swap banks once all are scanned; after a move the index has been bumped
        if (gsrc_r == size_r) begin
          bank_nxt = ~bank_r;
          size_nxt = {size_r[SW-2:0], 1'b0};
          tally_nxt = tally_r + 32'(moved_r);
          grow_nxt = 1'b0;
          st_nxt = qpht_pkg::S_DONE;
        end else begin
          raddr = {bank_r, gsrc_r[AW-1:0]};
          st_nxt = qpht_pkg::S_GCHK;
        end
      end
      qpht_pkg::S_GCHK: begin
        gsrc_nxt = gsrc_r + 1'b1;
        if (rtag == qpht_pkg::TAG_LIVE) begin
          key_nxt = rkey;
          val_nxt = rval;
          st_nxt = qpht_pkg::S_MIX_A;
        end else begin
          st_nxt = qpht_pkg::S_GRD;
        end
      end
      qpht_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        grow_nxt = 1'b0;
        st_nxt = qpht_pkg::S_IDLE;
      end
      default: begin
        st_nxt = qpht_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (st_r != qpht_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_status = ostat_r;
  assign out_read_value = orv_r;
  assign out_table_size = 11'(size_r);
  assign out_element_count = 11'(live_r);
  assign out_insert_count = tally_r;

endmodule
